// ===== src/vdp_pkg.sv =====
// vdp_pkg: constants and types shared by the vga dac palette and its checker
// no dependencies

package vdp_pkg;

  // default palette depth
  localparam int unsigned PALETTE_ENTRIES_DEFAULT = 256;

  // i/o port addresses of the dac
  localparam logic [15:0] PORT_INDEX = 16'h03C8;
  localparam logic [15:0] PORT_DATA  = 16'h03C9;

  localparam int unsigned CHAN_W  = 6;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned ENTRY_W = 3 * CHAN_W;

  // item kinds carried on tuser
  localparam logic KIND_PORT_WRITE = 1'b0;
  localparam logic KIND_LOOKUP     = 1'b1;

  // input word: port_address, data_value, pixel_index from bit 0 up
  localparam int unsigned S_TDATA_W = 32;
  // output word: red, green, blue levels from bit 0 up
  localparam int unsigned M_TDATA_W = 24;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [LEVEL_W-1:0] level_t;

  // 6-bit channel to 8-bit level
  function automatic level_t chan_to_level(input chan_t c);
    return {c, 2'b00};
  endfunction

endpackage

// ===== src/vga_dac_palette.sv =====
// vga_dac_palette: 6-bit rgb colour palette with port-write programming
// and a pixel lookup path; depends on vdp_pkg

// The slave stream takes one word per cycle unless stalled. tuser selects the
// kind: a port write (0) or a pixel lookup (1). A port write to 0x3C8 loads
// the entry index and arms the write sequence; the next three writes to 0x3C9
// give red, green and blue (low 6 bits kept), and the blue write stores the
// entry. There is no auto-increment. Data writes while not armed, and writes
// to any other port, are ignored; a port write never gives a result word. A
// lookup gives one result word with each channel of the entry shifted left by
// two; an index at or above PALETTE_ENTRIES reads as black. The palette sits
// in a single-port synchronous memory, written on the store and read on the
// lookup with a registered read. A per-entry valid flag, cleared by
// reset, makes never-written entries read as the power-on grey ramp (entry i:
// every channel i mod 64), so no clearing pass is needed after reset and the
// block is ready on the first cycle out of reset. Throughput is one word per
// cycle when not stalled, set by the single memory port: one read or one
// write per cycle. A lookup goes through a read stage and then an output
// register to the master stream; the two keep the input open while a result
// waits, and the input stalls only when both are full. As each word is
// either a read or a write, a store and a later lookup of the same entry
// never meet in one cycle and need no forwarding.

module vga_dac_palette #(
  parameter int unsigned PALETTE_ENTRIES = vdp_pkg::PALETTE_ENTRIES_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  // slave stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [15:0] port_address, [23:16] data_value, [31:24] pixel_index
  input  logic [vdp_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // [0] kind
  input  logic                           s_axis_tuser,
  // master stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [7:0] red_level, [15:8] green_level, [23:16] blue_level
  output logic [vdp_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

  localparam int unsigned IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam logic [8:0]  ENTRIES_9 = 9'(PALETTE_ENTRIES);

  typedef enum logic [1:0] {
    WS_IDLE,
    WS_RED,
    WS_GREEN,
    WS_BLUE
  } wstage_t;

  // input word fields
  logic [15:0] port_address;
  logic [7:0]  data_value;
  logic [7:0]  pixel_index;

  assign port_address = s_axis_tdata[15:0];
  assign data_value   = s_axis_tdata[23:16];
  assign pixel_index  = s_axis_tdata[31:24];

  // handshake and flow control
  logic in_acc;
  logic lookup_acc;
  logic write_acc;
  logic rd_move;

  // write sequencer
  wstage_t             write_stage;
  logic [7:0]          write_index;
  vdp_pkg::chan_t      held_red;
  vdp_pkg::chan_t      held_green;
  logic                store_en;

  // palette memory and per-entry written flags
  logic [vdp_pkg::ENTRY_W-1:0] palette_mem [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0]  entry_valid;
  logic [vdp_pkg::ENTRY_W-1:0] rdata;

  // read stage, lines up with the memory read data
  logic           rd_valid;
  logic           rd_in_range;
  logic           rd_written;
  vdp_pkg::chan_t rd_ramp;

  // output register
  logic              out_valid;
  vdp_pkg::level_t   red_level;
  vdp_pkg::level_t   green_level;
  vdp_pkg::level_t   blue_level;

  vdp_pkg::chan_t    sel_red;
  vdp_pkg::chan_t    sel_green;
  vdp_pkg::chan_t    sel_blue;

  // read stage drains when the output register is empty or being taken
  assign rd_move       = rd_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !rd_valid || rd_move;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign lookup_acc    = in_acc && (s_axis_tuser == vdp_pkg::KIND_LOOKUP);
  assign write_acc     = in_acc && (s_axis_tuser == vdp_pkg::KIND_PORT_WRITE);

  // blue data write completes the sequence; out-of-range stores are dropped
  assign store_en = write_acc && (port_address == vdp_pkg::PORT_DATA)
                    && (write_stage == WS_BLUE)
                    && ({1'b0, write_index} < ENTRIES_9);

  // write sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      write_stage <= WS_IDLE;
      write_index <= '0;
      held_red    <= '0;
      held_green  <= '0;
    end else if (write_acc) begin
      if (port_address == vdp_pkg::PORT_INDEX) begin
        write_index <= data_value;
        write_stage <= WS_RED;
      end else if (port_address == vdp_pkg::PORT_DATA) begin
        unique case (write_stage)
          WS_RED: begin
            held_red    <= data_value[vdp_pkg::CHAN_W-1:0];
            write_stage <= WS_GREEN;
          end
          WS_GREEN: begin
            held_green  <= data_value[vdp_pkg::CHAN_W-1:0];
            write_stage <= WS_BLUE;
          end
          WS_BLUE: begin
            write_stage <= WS_IDLE;
          end
          default: begin
            write_stage <= WS_IDLE;
          end
        endcase
      end
    end
  end

  // palette memory, one port: write on store, registered read on lookup
  always_ff @(posedge clk) begin
    if (store_en) begin
      palette_mem[write_index[IDX_W-1:0]] <=
        {held_red, held_green, data_value[vdp_pkg::CHAN_W-1:0]};
    end
    if (lookup_acc) begin
      rdata <= palette_mem[pixel_index[IDX_W-1:0]];
    end
  end

  // written flags, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (store_en) begin
      entry_valid[write_index[IDX_W-1:0]] <= 1'b1;
    end
  end

  // read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (lookup_acc) begin
      rd_valid <= 1'b1;
    end else if (rd_move) begin
      rd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (lookup_acc) begin
      rd_in_range <= ({1'b0, pixel_index} < ENTRIES_9);
      rd_written  <= entry_valid[pixel_index[IDX_W-1:0]];
      // grey ramp value of a never-written entry
      rd_ramp     <= pixel_index[vdp_pkg::CHAN_W-1:0];
    end
  end

  // pick stored, ramp or black
  always_comb begin
    if (!rd_in_range) begin
      sel_red   = '0;
      sel_green = '0;
      sel_blue  = '0;
    end else if (rd_written) begin
      sel_red   = rdata[3*vdp_pkg::CHAN_W-1:2*vdp_pkg::CHAN_W];
      sel_green = rdata[2*vdp_pkg::CHAN_W-1:vdp_pkg::CHAN_W];
      sel_blue  = rdata[vdp_pkg::CHAN_W-1:0];
    end else begin
      sel_red   = rd_ramp;
      sel_green = rd_ramp;
      sel_blue  = rd_ramp;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rd_move) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_move) begin
      red_level   <= vdp_pkg::chan_to_level(sel_red);
      green_level <= vdp_pkg::chan_to_level(sel_green);
      blue_level  <= vdp_pkg::chan_to_level(sel_blue);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {blue_level, green_level, red_level};

endmodule

// ===== src/vdp_checker.sv =====
// vdp_checker: port-level assertions for vga_dac_palette, bound to the top
// depends on vdp_pkg and vga_dac_palette

module vdp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [vdp_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input logic                          s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [vdp_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  logic lookup_acc;

  assign lookup_acc = s_axis_tvalid && s_axis_tready
                      && (s_axis_tuser == vdp_pkg::KIND_LOOKUP);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result word present after reset");

  // every lookup is followed by a valid result word
  a_lookup_result: assert property (@(posedge clk) disable iff (rst)
    lookup_acc |-> ##2 m_axis_tvalid)
    else $error("lookup gave no result word");

  // a fresh result word comes only from an earlier lookup
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(lookup_acc, 2))
    else $error("result word without lookup");

endmodule

bind vga_dac_palette vdp_checker u_vdp_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
